[design/assert_macros.svh]
// Assertion helpers shared by the design files.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/mrlc_pkg.sv]
`default_nettype none

package mrlc_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;
  localparam int CFG_BITS    = 20;
  localparam int LEN_BITS    = 20;
  localparam int CMP_BITS    = 32;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // Smoothed sum keys a mark when its truncated third is nonzero
  localparam logic signed [SUM_BITS-1:0] SUM_KEY_HI = SUM_BITS'(2);
  localparam logic signed [SUM_BITS-1:0] SUM_KEY_LO = -SUM_BITS'(2);

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DASH_MIN        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOT_MIN         = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_GAP_MIN    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LETTER_GAP_MIN  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ELEMENT_GAP_MIN = 3'd4;

  // Register reset values
  localparam logic [CFG_BITS-1:0] DASH_MIN_RST        = 20'd1000;
  localparam logic [CFG_BITS-1:0] DOT_MIN_RST         = 20'd300;
  localparam logic [CFG_BITS-1:0] WORD_GAP_MIN_RST    = 20'd1500;
  localparam logic [CFG_BITS-1:0] LETTER_GAP_MIN_RST  = 20'd600;
  localparam logic [CFG_BITS-1:0] ELEMENT_GAP_MIN_RST = 20'd0;

  // Result queue sizing
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int FREE_BITS   = 3;

  typedef enum logic [2:0] {
    SYM_DOT         = 3'd0,
    SYM_DASH        = 3'd1,
    SYM_LETTER_GAP  = 3'd2,
    SYM_WORD_GAP    = 3'd3,
    SYM_ELEMENT_GAP = 3'd4,
    SYM_TOO_SHORT   = 3'd5
  } sym_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_stream;
  } in_item_t;

  typedef struct packed {
    sym_t                symbol;
    logic [LEN_BITS-1:0] run_length;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] dash_min_run;
    logic [CFG_BITS-1:0] dot_min_run;
    logic [CFG_BITS-1:0] word_gap_min_run;
    logic [CFG_BITS-1:0] letter_gap_min_run;
    logic [CFG_BITS-1:0] element_gap_min_run;
  } cfg_t;

  // Results of one processed item, packed from index 0 upwards
  typedef struct packed {
    logic [1:0]                  n;
    out_item_t [MAX_RESULTS-1:0] item;
  } push_t;

  // Classify a finished run against the thresholds, tests in priority order
  function automatic sym_t classify(logic level, logic [CMP_BITS-1:0] cnt, cfg_t cfg);
    sym_t sym;
    if (level) begin
      if (cnt > CMP_BITS'(cfg.dash_min_run))             sym = SYM_DASH;
      else if (cnt > CMP_BITS'(cfg.dot_min_run))         sym = SYM_DOT;
      else                                               sym = SYM_TOO_SHORT;
    end else begin
      if (cnt > CMP_BITS'(cfg.word_gap_min_run))         sym = SYM_WORD_GAP;
      else if (cnt > CMP_BITS'(cfg.letter_gap_min_run))  sym = SYM_LETTER_GAP;
      else if (cnt > CMP_BITS'(cfg.element_gap_min_run)) sym = SYM_ELEMENT_GAP;
      else                                               sym = SYM_TOO_SHORT;
    end
    return sym;
  endfunction

endpackage

`default_nettype wire

[design/morse_run_length_classifier_unit.sv]
`default_nettype none

// Flow: each sample is held in the input register until the queue has room for its results.
// Throughput: one sample per cycle while the queue has room; the final sample of a
//   stream yields up to three results, sent one per cycle while out_stall is low, from
//   a four-entry result queue that holds off input.
// Reset: synchronous active-low rst_n empties the pipeline and queue, clears the stream
//   state and loads the default thresholds.

module morse_run_length_classifier_unit #(
  parameter int RUN_COUNT_BITS = 20
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire mrlc_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output mrlc_pkg::out_item_t                   out_data,
  input  wire                                   cfg_we,
  input  wire [mrlc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire [mrlc_pkg::CFG_BITS-1:0]          cfg_data
);
  import mrlc_pkg::*;

  cfg_t                 cfg_r;
  push_t                push;
  logic [FREE_BITS-1:0] free_slots;

  // Threshold registers; writes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dash_min_run        <= DASH_MIN_RST;
      cfg_r.dot_min_run         <= DOT_MIN_RST;
      cfg_r.word_gap_min_run    <= WORD_GAP_MIN_RST;
      cfg_r.letter_gap_min_run  <= LETTER_GAP_MIN_RST;
      cfg_r.element_gap_min_run <= ELEMENT_GAP_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DASH_MIN:        cfg_r.dash_min_run        <= cfg_data;
        REG_DOT_MIN:         cfg_r.dot_min_run         <= cfg_data;
        REG_WORD_GAP_MIN:    cfg_r.word_gap_min_run    <= cfg_data;
        REG_LETTER_GAP_MIN:  cfg_r.letter_gap_min_run  <= cfg_data;
        REG_ELEMENT_GAP_MIN: cfg_r.element_gap_min_run <= cfg_data;
        default: ;
      endcase
    end
  end

  mrlc_core #(
    .RUN_COUNT_BITS (RUN_COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .free_slots (free_slots),
    .push       (push)
  );

  mrlc_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .free_slots (free_slots),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

[design/mrlc_core.sv]
`default_nettype none

`include "assert_macros.svh"

module mrlc_core #(
  parameter int RUN_COUNT_BITS = 20
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire mrlc_pkg::in_item_t             in_data,
  input  wire mrlc_pkg::cfg_t                 cfg,
  input  wire [mrlc_pkg::FREE_BITS-1:0]       free_slots,
  output mrlc_pkg::push_t                     push
);
  import mrlc_pkg::*;

  typedef struct packed {
    logic                      mark;
    logic                      level;
    logic [RUN_COUNT_BITS-1:0] count;
  } run_t;

  localparam logic [RUN_COUNT_BITS-1:0] COUNT_ONE = RUN_COUNT_BITS'(1);
  localparam logic [RUN_COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam run_t RUN_CLEAR = '{mark: 1'b0, level: 1'b0, count: '0};

  // Open run after one keyed level: skip leading space, extend or restart
  function automatic run_t run_next(run_t s, logic key);
    run_t r;
    r = s;
    if (!s.mark) begin
      if (key) begin
        r.mark  = 1'b1;
        r.level = 1'b1;
        r.count = COUNT_ONE;
      end
    end else if (key == s.level) begin
      if (s.count != COUNT_MAX) r.count = s.count + COUNT_ONE;
    end else begin
      r.level = key;
      r.count = COUNT_ONE;
    end
    return r;
  endfunction

  // Build a result for a finished run
  function automatic out_item_t make_result(run_t s, cfg_t c);
    out_item_t o;
    logic [CMP_BITS-1:0] cnt;
    cnt = CMP_BITS'(s.count);
    o.symbol      = classify(s.level, cnt, c);
    o.run_length  = (cnt > CMP_BITS'(LEN_MAX)) ? LEN_MAX : cnt[LEN_BITS-1:0];
    o.last_of_run = 1'b0;
    return o;
  endfunction

  logic                          item_valid_r;
  in_item_t                      item_r;
  logic signed [SAMPLE_BITS-1:0] older_r, older_nxt;
  logic signed [SAMPLE_BITS-1:0] newer_r, newer_nxt;
  logic [1:0]                    seen_r, seen_nxt;
  run_t                          run_r, run_nxt;

  logic signed [SUM_BITS-1:0] sum_a;
  logic      key_a, key_b;
  logic      emit_a, emit_b, emit_c;
  run_t      run_1, run_2;
  out_item_t res_a, res_b, res_c;
  logic [1:0] n_res;
  logic      advance;

  // Smoothing of the held sample and the level it keys
  always_comb begin
    sum_a = SUM_BITS'(older_r) + SUM_BITS'(newer_r) + SUM_BITS'(item_r.sample);
    if (seen_r == 2'd1) key_a = (newer_r != '0);
    else                key_a = (sum_a > SUM_KEY_HI) || (sum_a < SUM_KEY_LO);
    key_b = (item_r.sample != '0);
  end

  // Run tracking: held sample first, then the final sample and flush
  always_comb begin
    emit_a = (seen_r != 2'd0) && run_r.mark && (key_a != run_r.level);
    run_1  = (seen_r != 2'd0) ? run_next(run_r, key_a) : run_r;
    emit_b = item_r.end_of_stream && run_1.mark && (key_b != run_1.level);
    run_2  = run_next(run_1, key_b);
    emit_c = item_r.end_of_stream && run_2.mark;
    res_a  = make_result(run_r, cfg);
    res_b  = make_result(run_1, cfg);
    res_c  = make_result(run_2, cfg);
    n_res  = 2'(emit_a) + 2'(emit_b) + 2'(emit_c);
  end

  // Pack results in order and flag the final one
  always_comb begin
    push.n       = advance ? n_res : 2'd0;
    push.item[0] = emit_a ? res_a : (emit_b ? res_b : res_c);
    push.item[1] = (emit_a && emit_b) ? res_b : res_c;
    push.item[2] = res_c;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      push.item[i].last_of_run = (2'(i) == (n_res - 2'd1));
    end
  end

  // Advance only when the queue has room for every result of this item
  assign advance  = item_valid_r && (FREE_BITS'(n_res) <= free_slots);
  assign in_stall = item_valid_r && !advance;

  // Next stream state
  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    seen_nxt  = seen_r;
    run_nxt   = run_r;
    if (advance) begin
      if (item_r.end_of_stream) begin
        older_nxt = '0;
        newer_nxt = '0;
        seen_nxt  = 2'd0;
        run_nxt   = RUN_CLEAR;
      end else begin
        older_nxt = newer_r;
        newer_nxt = item_r.sample;
        seen_nxt  = (seen_r == 2'd2) ? 2'd2 : seen_r + 2'd1;
        run_nxt   = run_1;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      seen_r  <= 2'd0;
      run_r   <= RUN_CLEAR;
    end else begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      seen_r  <= seen_nxt;
      run_r   <= run_nxt;
    end
  end

  `ASSERT_NEXT(a_eos_clears, advance && item_r.end_of_stream, (seen_r == 2'd0) && !run_r.mark && (run_r.count == '0), "stream state not cleared after final sample")
  `ASSERT_NEXT(a_sample_held, advance && !item_r.end_of_stream, seen_r != 2'd0, "sample history lost after transfer")

endmodule

`default_nettype wire

[design/mrlc_out_queue.sv]
`default_nettype none

`include "assert_macros.svh"

module mrlc_out_queue (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire mrlc_pkg::push_t            push,
  output logic [mrlc_pkg::FREE_BITS-1:0]  free_slots,
  output logic                            out_valid,
  input  wire                             out_stall,
  output mrlc_pkg::out_item_t             out_data
);
  import mrlc_pkg::*;

  out_item_t            slot_r   [QUEUE_DEPTH];
  out_item_t            slot_nxt [QUEUE_DEPTH];
  out_item_t            shifted  [QUEUE_DEPTH];
  logic [FREE_BITS-1:0] cnt_r, cnt_nxt;
  logic [FREE_BITS-1:0] kept;
  logic [FREE_BITS-1:0] off;
  logic                 pop;

  assign out_valid  = (cnt_r != '0);
  assign out_data   = slot_r[0];
  assign pop        = out_valid && !out_stall;
  assign kept       = cnt_r - FREE_BITS'(pop);
  assign free_slots = FREE_BITS'(QUEUE_DEPTH) - kept;
  assign cnt_nxt    = kept + FREE_BITS'(push.n);

  // Drop the head on a transfer, then append new results behind the kept ones
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      shifted[i] = pop ? slot_r[i+1] : slot_r[i];
    end
    shifted[QUEUE_DEPTH-1] = slot_r[QUEUE_DEPTH-1];
    off = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      off = FREE_BITS'(i) - kept;
      if (FREE_BITS'(i) < kept) begin
        slot_nxt[i] = shifted[i];
      end else if (off < FREE_BITS'(push.n)) begin
        if (off[1:0] == 2'd0)      slot_nxt[i] = push.item[0];
        else if (off[1:0] == 2'd1) slot_nxt[i] = push.item[1];
        else                       slot_nxt[i] = push.item[2];
      end else begin
        slot_nxt[i] = shifted[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, cnt_r <= FREE_BITS'(QUEUE_DEPTH), "result queue overflow")
  `ASSERT_NEXT(a_held_result, out_valid && out_stall, out_valid, "stalled result lost")
  `ASSERT_ALWAYS(a_push_fits, FREE_BITS'(push.n) <= free_slots, "results pushed without room")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrlc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int ITEMS_PER_SET   = 45;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_LO  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_TOP = 3'd7;

  typedef enum {ROW_FEED, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] reg_idx;
    logic [CFG_BITS-1:0]       reg_val;
    in_item_t                  item;
    bit                        typed;
    int                        typed_n;
    out_item_t                 typed_res;
  } script_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_item_t                 out_data;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  // Predictor state: sample history, open run and thresholds
  logic signed [SAMPLE_BITS-1:0] hist_old;
  logic signed [SAMPLE_BITS-1:0] hist_new;
  int                            hist_fill;
  bit                            open_level;
  logic [LEN_BITS-1:0]           open_len;
  bit                            keyed_yet;
  cfg_t                          thr;

  out_item_t   run_batch[$];
  out_item_t   expected_runs[$];
  script_row_t script[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int quiet_cycles;
  int items_sent;
  logic hold_off_req;

  morse_run_length_classifier_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Classify a finished run, tests in priority order
  function automatic sym_t grade_run(bit lvl, logic [LEN_BITS-1:0] len);
    if (lvl) begin
      if (len > thr.dash_min_run) return SYM_DASH;
      if (len > thr.dot_min_run) return SYM_DOT;
      return SYM_TOO_SHORT;
    end
    if (len > thr.word_gap_min_run) return SYM_WORD_GAP;
    if (len > thr.letter_gap_min_run) return SYM_LETTER_GAP;
    if (len > thr.element_gap_min_run) return SYM_ELEMENT_GAP;
    return SYM_TOO_SHORT;
  endfunction

  function automatic void close_run();
    out_item_t r;
    r.symbol      = grade_run(open_level, open_len);
    r.run_length  = open_len;
    r.last_of_run = 1'b0;
    run_batch = {run_batch, r};
  endfunction

  // Extend the open run or close it on a level change; skip leading silence
  function automatic void take_key(bit k);
    if (!keyed_yet) begin
      if (k) begin
        keyed_yet  = 1'b1;
        open_level = 1'b1;
        open_len   = 1;
      end
    end else if (k == open_level) begin
      if (open_len != LEN_MAX) open_len++;
    end else begin
      close_run();
      open_level = k;
      open_len   = 1;
    end
  endfunction

  function automatic void clear_stream();
    hist_old   = '0;
    hist_new   = '0;
    hist_fill  = 0;
    open_level = 1'b0;
    open_len   = '0;
    keyed_yet  = 1'b0;
  endfunction

  // Smooth the held sample one step late, then flush on end of stream
  function automatic void track_sample(in_item_t item);
    int sum;
    run_batch.delete();
    if (hist_fill == 1) begin
      take_key(hist_new != 0);
    end else if (hist_fill == 2) begin
      sum = int'(hist_old) + int'(hist_new) + int'(item.sample);
      take_key((sum / 3) != 0);
    end
    hist_old = hist_new;
    hist_new = item.sample;
    if (hist_fill < 2) hist_fill++;
    if (item.end_of_stream) begin
      take_key(item.sample != 0);
      if (keyed_yet) close_run();
      clear_stream();
    end
    if (run_batch.size() > 0) run_batch[run_batch.size()-1].last_of_run = 1'b1;
  endfunction

  function automatic script_row_t feed(logic signed [SAMPLE_BITS-1:0] s, bit eos);
    script_row_t r;
    r.kind               = ROW_FEED;
    r.reg_idx            = '0;
    r.reg_val            = '0;
    r.item.sample        = s;
    r.item.end_of_stream = eos;
    r.typed              = 1'b0;
    r.typed_n            = 0;
    r.typed_res          = '0;
    return r;
  endfunction

  function automatic script_row_t feed_known(logic signed [SAMPLE_BITS-1:0] s, bit eos,
                                             int n, sym_t sym, logic [LEN_BITS-1:0] len);
    script_row_t r;
    r                       = feed(s, eos);
    r.typed                 = 1'b1;
    r.typed_n               = n;
    r.typed_res.symbol      = sym;
    r.typed_res.run_length  = len;
    r.typed_res.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic script_row_t set_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                          logic [CFG_BITS-1:0] v);
    script_row_t r;
    r         = feed(0, 1'b0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = v;
    return r;
  endfunction

  // Offer one sample, hold it until transferred, then queue its runs
  task automatic send_item(in_item_t item, bit typed, int typed_n, out_item_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    track_sample(item);
    if (typed) begin
      if (typed_n > 0) expected_runs = {expected_runs, typed_res};
    end else begin
      expected_runs = {expected_runs, run_batch};
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_DASH_MIN:        thr.dash_min_run        = v;
      REG_DOT_MIN:         thr.dot_min_run         = v;
      REG_WORD_GAP_MIN:    thr.word_gap_min_run    = v;
      REG_LETTER_GAP_MIN:  thr.letter_gap_min_run  = v;
      REG_ELEMENT_GAP_MIN: thr.element_gap_min_run = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_thresholds(cfg_t c);
    write_reg(REG_DASH_MIN, c.dash_min_run);
    write_reg(REG_DOT_MIN, c.dot_min_run);
    write_reg(REG_WORD_GAP_MIN, c.word_gap_min_run);
    write_reg(REG_LETTER_GAP_MIN, c.letter_gap_min_run);
    write_reg(REG_ELEMENT_GAP_MIN, c.element_gap_min_run);
    write_reg(REG_UNMAPPED_TOP, CFG_BITS'($urandom));
  endtask

  // Ordered small, all zero, unordered small, all ones
  function automatic cfg_t pick_thresholds(int which);
    cfg_t c;
    case (which % 6)
      0, 4: begin
        c.dot_min_run         = CFG_BITS'($urandom_range(1, 3));
        c.dash_min_run        = c.dot_min_run + CFG_BITS'($urandom_range(1, 4));
        c.element_gap_min_run = CFG_BITS'($urandom_range(0, 1));
        c.letter_gap_min_run  = c.element_gap_min_run + CFG_BITS'($urandom_range(1, 3));
        c.word_gap_min_run    = c.letter_gap_min_run + CFG_BITS'($urandom_range(1, 4));
      end
      1: c = '0;
      3: c = '1;
      default: begin
        c.dash_min_run        = CFG_BITS'($urandom_range(0, 10));
        c.dot_min_run         = CFG_BITS'($urandom_range(0, 10));
        c.word_gap_min_run    = CFG_BITS'($urandom_range(0, 10));
        c.letter_gap_min_run  = CFG_BITS'($urandom_range(0, 10));
        c.element_gap_min_run = CFG_BITS'($urandom_range(0, 10));
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] mark_level();
    logic signed [SAMPLE_BITS-1:0] v;
    if ($urandom_range(0, 3) == 0) v = SAMPLE_BITS'($urandom_range(1, 4));
    else v = SAMPLE_BITS'($urandom_range(1, 32767));
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] space_level();
    if ($urandom_range(0, 7) == 0) return SAMPLE_BITS'(($urandom_range(0, 1) == 1) ? 1 : -1);
    return '0;
  endfunction

  // One stream: mostly alternating runs, else noise, silence or a lone sample
  task automatic send_stream();
    logic signed [SAMPLE_BITS-1:0] smp[$];
    in_item_t it;
    int shape;
    int runs;
    int len;
    shape = $urandom_range(0, 99);
    if (shape < 70) begin
      repeat ($urandom_range(0, 3)) smp = {smp, SAMPLE_BITS'(0)};
      runs = $urandom_range(1, 7);
      for (int r = 0; r < runs; r++) begin
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 10);
        repeat (len) smp = {smp, ((r % 2 == 0) ? mark_level() : space_level())};
      end
    end else if (shape < 85) begin
      repeat ($urandom_range(1, 12)) smp = {smp, SAMPLE_BITS'($urandom)};
    end else if (shape < 95) begin
      repeat ($urandom_range(1, 6)) smp = {smp, SAMPLE_BITS'(0)};
    end else begin
      smp = {smp, SAMPLE_BITS'($urandom)};
    end
    foreach (smp[i]) begin
      it.sample        = smp[i];
      it.end_of_stream = (i == smp.size() - 1);
      send_item(it, 1'b0, 0, '0);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Compare each transferred result with the oldest expected run
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected result: symbol %0d run_length %0d last_of_run %0d",
               out_data.symbol, out_data.run_length, out_data.last_of_run);
        fail_count++;
      end else begin
        want = expected_runs.pop_front();
        if (out_data.symbol !== want.symbol) begin
          $error("symbol: expected %0d, actual %0d", want.symbol, out_data.symbol);
          fail_count++;
        end
        if (out_data.run_length !== want.run_length) begin
          $error("run_length: expected %0d, actual %0d", want.run_length,
                 out_data.run_length);
          fail_count++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                 out_data.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // End the run when nothing has been transferred for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_off_req  = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 65;
    fail_count    = 0;
    quiet_cycles  = 0;
    items_sent    = 0;
    thr = {DASH_MIN_RST, DOT_MIN_RST, WORD_GAP_MIN_RST, LETTER_GAP_MIN_RST,
           ELEMENT_GAP_MIN_RST};
    clear_stream();

    // Lone-sample streams under reset thresholds, then tight thresholds
    // and a stream with truncation, trailing space and extremes
    script = '{
      feed_known(32767, 1'b1, 1, SYM_TOO_SHORT, 1),
      feed_known(0, 1'b1, 0, SYM_TOO_SHORT, 0),
      feed_known(-32768, 1'b1, 1, SYM_TOO_SHORT, 1),
      set_reg(REG_DASH_MIN, 3),
      set_reg(REG_DOT_MIN, 1),
      set_reg(REG_WORD_GAP_MIN, 4),
      set_reg(REG_LETTER_GAP_MIN, 2),
      set_reg(REG_ELEMENT_GAP_MIN, 1),
      set_reg(REG_UNMAPPED_LO, 0),
      feed(0, 1'b0), feed(0, 1'b0), feed(1, 1'b0), feed(1, 1'b0),
      feed(0, 1'b0), feed(-1, 1'b0), feed(-1, 1'b0), feed(0, 1'b0),
      feed(32767, 1'b0), feed(32767, 1'b0), feed(32767, 1'b0),
      feed(0, 1'b0), feed(0, 1'b0), feed(0, 1'b0), feed(0, 1'b0),
      feed(-32768, 1'b0), feed(-32768, 1'b0), feed(0, 1'b0), feed(0, 1'b0),
      feed(100, 1'b0), feed(0, 1'b0), feed(0, 1'b1)
    };

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) write_reg(script[i].reg_idx, script[i].reg_val);
      else send_item(script[i].item, script[i].typed, script[i].typed_n,
                     script[i].typed_res);
    end

    // Three idling phases, two threshold sets each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 33; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < 2; k++) begin
        load_thresholds(pick_thresholds(ph * 2 + k));
        if (ph == 2 && k == 0) hold_off_req <= 1'b1;
        items_sent = 0;
        while (items_sent < ITEMS_PER_SET) send_stream();
      end
    end

    // Drain outstanding runs, then let the block idle before reporting
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
